@@ src/assert_macros.svh @@
// assertion macros shared by the distance unit modules
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ED_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition at one edge implies a consequence at the next
`define ED_ASSERT_NEXT(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) else $error(msg);

`endif

@@ src/eds_pkg.sv @@
// types and constants for the euclidean distance stream unit
// no dependencies
`default_nettype none

package eds_pkg;

   localparam int ELEM_W     = 24;
   localparam int MAG_W      = ELEM_W + 1;
   localparam int SQ_W       = 2 * ELEM_W + 1;
   localparam int SUM_W      = 60;
   localparam int DIST_W     = 29;
   localparam int BIT_W      = SUM_W - 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [SUM_W-1:0] DIST_MAX = {{(SUM_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

   typedef struct packed {
      logic signed [ELEM_W-1:0] a_elem;
      logic signed [ELEM_W-1:0] b_elem;
      logic                     a_last;
      logic                     b_last;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              length_mismatch;
   } rsp_type;

   // finished sum handed from front end to back end
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             mismatch;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/eds_front.sv @@
// front end: difference, square and saturating accumulation of element pairs
// depends on eds_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module eds_front import eds_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire req_type          req_data,
   output logic                  req_full,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output job_type               q_job
);

   logic                    s1_valid_ff, s1_valid_in;
   logic [MAG_W-1:0]        s1_mag_ff, s1_mag_in;
   logic                    s1_alast_ff, s1_blast_ff;
   logic                    s2_valid_ff, s2_valid_in;
   logic [SQ_W-1:0]         s2_sq_ff, s2_sq_in;
   logic                    s2_alast_ff, s2_blast_ff;
   logic [SUM_W-1:0]        sum_ff, sum_in;

   logic signed [MAG_W-1:0] diff;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        sum_sat;
   logic                    s2_end;
   logic                    stall;

   assign diff = $signed({req_data.a_elem[ELEM_W-1], req_data.a_elem})
               - $signed({req_data.b_elem[ELEM_W-1], req_data.b_elem});

   assign s2_end = s2_valid_ff && (s2_alast_ff || s2_blast_ff);
   assign stall  = s2_end && q_status.full;
   assign req_full = stall;

   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W+1-SQ_W){1'b0}}, s2_sq_ff};
   assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   always_comb begin
      s1_valid_in = req_push;
      s1_mag_in   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      s2_valid_in = s1_valid_ff;
      s2_sq_in    = SQ_W'(s1_mag_ff * s1_mag_ff);
      sum_in      = sum_ff;
      if (s2_valid_ff) begin
         sum_in = s2_end ? '0 : sum_sat;
      end
   end

   assign q_push       = s2_end && !stall;
   assign q_job.sum      = sum_sat;
   assign q_job.mismatch = s2_alast_ff != s2_blast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else if (!stall) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_mag_ff   <= s1_mag_in;
         s1_alast_ff <= req_data.a_last;
         s1_blast_ff <= req_data.b_last;
         s2_sq_ff    <= s2_sq_in;
         s2_alast_ff <= s1_alast_ff;
         s2_blast_ff <= s1_blast_ff;
      end
   end

   `ED_ASSERT_NEXT(a_stall_holds_end, stall, s2_valid_ff && $stable(s2_sq_ff), "stalled end item lost")
   `ED_ASSERT(a_push_has_room, !(q_push && q_status.full), "push into full queue")

endmodule

`default_nettype wire

@@ src/eds_queue.sv @@
// short queue of finished sums between front end and back end
// depends on eds_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module eds_queue import eds_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire job_type     push_job,
   input  wire logic        pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ED_ASSERT(a_count_bound, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count out of range")
   `ED_ASSERT(a_ptr_gap, (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_W-1:0], "pointers disagree with count")

endmodule

`default_nettype wire

@@ src/eds_back.sv @@
// back end: iterative integer square root and result register
// depends on eds_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module eds_back import eds_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire job_type          q_job,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rsp_type               rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] root_ff, root_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             mismatch_ff, mismatch_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic [SUM_W-1:0] trial;
   logic             slot_free;

   assign trial     = root_ff + {1'b0, bit_ff};
   assign slot_free = !out_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      mismatch_in  = mismatch_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               rem_in      = q_job.sum;
               root_in     = '0;
               bit_in      = {1'b1, {(BIT_W-1){1'b0}}};
               mismatch_in = q_job.mismatch;
               state_in    = q_job.mismatch ? ST_HOLD : ST_CALC;
            end
         end
         ST_CALC: begin
            // one result bit per cycle
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in.length_mismatch = mismatch_ff;
               if (root_ff > DIST_MAX) begin
                  out_in.distance = DIST_MAX[DIST_W-1:0];
               end else begin
                  out_in.distance = root_ff[DIST_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      mismatch_ff <= mismatch_in;
      out_ff      <= out_in;
   end

   `ED_ASSERT(a_calc_bit_onehot, (state_ff != ST_CALC) || $onehot(bit_ff), "root step bit lost")
   `ED_ASSERT(a_mismatch_no_root, (state_ff != ST_HOLD) || !mismatch_ff || (root_ff == '0), "mismatch with root")

endmodule

`default_nettype wire

@@ src/euclidean_distance_stream_unit.sv @@
// top level of the euclidean distance stream unit
// depends on eds_pkg, eds_front, eds_queue, eds_back and assert_macros.svh
`default_nettype none

//  channel   ports                              direction  payload
//  request   req_push, req_full, req_data       in         req_type: a_elem, b_elem, a_last, b_last
//  result    rsp_pop, rsp_empty, rsp_data       out        rsp_type: distance, length_mismatch
//
// one request per cycle enters the front pipeline (difference, square, accumulate)
// while req_full is low, and the front end never stalls on its own
// the back end takes one sum at a time through its one-bit-per-cycle root loop
// a four-entry queue of finished sums sits between them; when it is full and an end element
// reaches the accumulator, req_full rises and the whole front pipeline holds
// synchronous reset clears the sum, pipeline valids, queue pointers and result valid flag;
// there is no clearing pass

module euclidean_distance_stream_unit import eds_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data
);

   // front to queue
   logic             q_push;
   job_type          q_push_job;
   // queue to back
   logic             q_pop;
   job_type          q_head_job;
   queue_status_type q_status;

   // squares and sums element pairs, hands finished sums over
   eds_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_status (q_status),
      .q_push   (q_push),
      .q_job    (q_push_job)
   );

   // decouples the per-element front from the per-vector root
   eds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .status   (q_status)
   );

   // floor square root with saturation, result register towards the consumer
   eds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (q_head_job),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
